/* sv/pph_pkg.sv */
package pph_pkg;

    // Histogram geometry and timestamp width
    localparam int NUM_BINS    = 101;
    localparam int STAMP_WIDTH = 32;
    localparam int BIN_W       = $clog2(NUM_BINS);

    // Field widths
    localparam int OP_W        = 2;
    localparam int TS_W        = 32;
    localparam int IDX_W       = 7;
    localparam int TIME_W      = 14;
    localparam int COUNT_W     = 16;
    localparam int LL_W        = 14;
    localparam int IC_W        = 16;
    localparam int SEEN_W      = 17;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_LIMIT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_COUNT = 1'b1;

    // Limits and defaults
    localparam logic [LL_W-1:0]    LOWER_MIN     = 14'd50;
    localparam logic [LL_W-1:0]    LOWER_MAX     = 14'd9950;
    localparam logic [LL_W-1:0]    LOWER_DEFAULT = 14'd950;
    localparam logic [IC_W-1:0]    COUNT_DEFAULT = 16'd1000;
    localparam logic [SEEN_W-1:0]  WARMUP        = 17'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [TIME_W-1:0]  TIME_MAX      = 14'h3FFF;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CALC  = 4'b0010,
        S_RMW   = 4'b0100,
        S_RDATA = 4'b1000
    } state_t;

endpackage

/* sv/pph_in_if.sv */
interface pph_in_if;
    logic                          valid;
    logic                          ready;
    logic [pph_pkg::OP_W-1:0]      op;
    logic [pph_pkg::TS_W-1:0]      timestamp;
    logic [pph_pkg::IDX_W-1:0]     bin_index;

    modport source (output valid, output op, output timestamp, output bin_index, input ready);
    modport sink   (input valid, input op, input timestamp, input bin_index, output ready);
endinterface

/* sv/pph_out_if.sv */
interface pph_out_if;
    logic                          valid;
    logic                          ready;
    logic [pph_pkg::TIME_W-1:0]    bin_time;
    logic [pph_pkg::COUNT_W-1:0]   bin_count;
    logic                          done_res;
    logic [pph_pkg::COUNT_W-1:0]   dropped;

    modport source (output valid, output bin_time, output bin_count, output done_res,
                    output dropped, input ready);
    modport sink   (input valid, input bin_time, input bin_count, input done_res,
                    input dropped, output ready);
endinterface

/* sv/pph_ram.sv */
module pph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 101
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/pulse_period_histogram.sv */
// Pulse period histogram.
// Input channel req carries one beat per command: start (clear the run), capture
// (a timestamp from the capture counter) or read (one bin). Every beat gives exactly
// one result beat on rsp: the bin period and count for a read, zeros otherwise,
// together with the done flag and the count of out-of-range periods.
// Registers lower_limit and interval_count are written over cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block has no check. A
// lower_limit outside 50..9950 loads 950. Start, ignored and warm-up captures, the
// unused op and reads outside the store load their result on accept. A read passes
// through the bin RAM read; a capture whose period falls outside the bins, through
// the period subtract and range check; a counted capture, through the subtract, the
// bin RAM read and the write back. Items are handled one at a time: with rsp ready,
// the next beat is taken the cycle after the result is loaded, so throughput is one
// item per cycle for those loaded on accept; the others hold off the next beat until
// their result is loaded. At reset the bins read as zero (per-bin valid bits),
// counters clear and the registers take their defaults; no clearing pass is needed,
// and a start clears the bins the same way. When rsp stalls, the result holds in the
// output register and the next beat waits until it is taken.
module pulse_period_histogram (
    input  logic                                clk,
    input  logic                                rst_n,
    pph_in_if.sink                              req,
    pph_out_if.source                           rsp,
    input  logic                                cfg_we,
    input  logic [pph_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pph_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SW = pph_pkg::STAMP_WIDTH;
    localparam int BW = pph_pkg::BIN_W;
    localparam int NB = pph_pkg::NUM_BINS;

    // Control state
    pph_pkg::state_t                 state_reg, state_next;
    logic [NB-1:0]                   valid_reg, valid_next;
    logic [SW-1:0]                   prev_reg, prev_next;
    logic [pph_pkg::SEEN_W-1:0]      seen_reg, seen_next;
    logic [pph_pkg::COUNT_W-1:0]     drop_reg, drop_next;
    logic [pph_pkg::LL_W-1:0]        lower_reg;
    logic [pph_pkg::IC_W-1:0]        icount_reg;
    logic                            out_valid_reg, out_valid_next;

    // Payload state
    logic [SW-1:0]                   period_reg, period_next;
    logic [BW-1:0]                   bin_reg, bin_next;
    logic [pph_pkg::TIME_W-1:0]      time_reg, time_next;
    logic                            rd_valid_reg, rd_valid_next;
    logic [pph_pkg::TIME_W-1:0]      out_time_reg, out_time_next;
    logic [pph_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;
    logic                            out_done_reg, out_done_next;
    logic [pph_pkg::COUNT_W-1:0]     out_drop_reg, out_drop_next;

    // RAM port signals
    logic                            ram_we;
    logic [BW-1:0]                   ram_waddr;
    logic [pph_pkg::COUNT_W-1:0]     ram_wdata;
    logic                            ram_re;
    logic [BW-1:0]                   ram_raddr;
    logic [pph_pkg::COUNT_W-1:0]     ram_rdata;

    // Combinational helpers
    logic                            slot_free;
    logic                            accept;
    logic                            done_now;
    logic [pph_pkg::SEEN_W-1:0]      done_limit;
    logic                            emit;
    logic [pph_pkg::TIME_W-1:0]      emit_time;
    logic [pph_pkg::COUNT_W-1:0]     emit_count;
    logic [SW:0]                     diff;
    logic                            period_in_range;
    logic [pph_pkg::TIME_W:0]        time_sum;
    logic [pph_pkg::COUNT_W-1:0]     cur_count;
    logic [pph_pkg::LL_W-1:0]        cfg_lower;

    pph_ram #(
        .WIDTH (pph_pkg::COUNT_W),
        .DEPTH (NB)
    ) u_bins (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .re      (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Handshake
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == pph_pkg::S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.bin_time  = out_time_reg;
    assign rsp.bin_count = out_count_reg;
    assign rsp.done_res  = out_done_reg;
    assign rsp.dropped   = out_drop_reg;

    // Run completion against the current capture count
    assign done_limit = pph_pkg::SEEN_W'(icount_reg) + pph_pkg::WARMUP;
    assign done_now   = (seen_reg >= done_limit);

    // Period minus lower limit picks the bin
    assign diff = {1'b0, period_reg} - (SW + 1)'(lower_reg);
    assign period_in_range = !diff[SW] && (diff[SW-1:0] < SW'(NB));

    // Period label of a read bin
    assign time_sum = (pph_pkg::TIME_W + 1)'(lower_reg)
                    + (pph_pkg::TIME_W + 1)'(req.bin_index);

    // Bin count seen by the read-modify-write
    assign cur_count = rd_valid_reg ? ram_rdata : '0;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        prev_next      = prev_reg;
        seen_next      = seen_reg;
        drop_next      = drop_reg;
        period_next    = period_reg;
        bin_next       = bin_reg;
        time_next      = time_reg;
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_time_next  = out_time_reg;
        out_count_next = out_count_reg;
        out_done_next  = out_done_reg;
        out_drop_next  = out_drop_reg;
        ram_we         = 1'b0;
        ram_waddr      = bin_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = bin_reg;
        emit           = 1'b0;
        emit_time      = '0;
        emit_count     = '0;

        case (state_reg)
            pph_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        pph_pkg::OP_START:
                        begin
                            valid_next = '0;
                            prev_next  = '0;
                            seen_next  = '0;
                            drop_next  = '0;
                            emit       = 1'b1;
                        end
                        pph_pkg::OP_CAPTURE:
                        begin
                            if (!done_now)
                            begin
                                prev_next = req.timestamp[SW-1:0];
                                seen_next = seen_reg + 1'b1;
                                if (seen_reg >= pph_pkg::WARMUP)
                                begin
                                    period_next = req.timestamp[SW-1:0] - prev_reg;
                                    state_next  = pph_pkg::S_CALC;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        pph_pkg::OP_READ:
                        begin
                            if (int'(req.bin_index) < NB)
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = BW'(req.bin_index);
                                rd_valid_next = valid_reg[BW'(req.bin_index)];
                                time_next     = time_sum[pph_pkg::TIME_W]
                                              ? pph_pkg::TIME_MAX
                                              : time_sum[pph_pkg::TIME_W-1:0];
                                state_next    = pph_pkg::S_RDATA;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            pph_pkg::S_CALC:
            begin
                if (period_in_range)
                begin
                    // Fetch the bin for the increment
                    ram_re        = 1'b1;
                    ram_raddr     = diff[BW-1:0];
                    rd_valid_next = valid_reg[diff[BW-1:0]];
                    bin_next      = diff[BW-1:0];
                    state_next    = pph_pkg::S_RMW;
                end
                else if (slot_free)
                begin
                    // Count the out-of-range period, saturating
                    if (drop_reg != pph_pkg::COUNT_MAX)
                    begin
                        drop_next = drop_reg + 1'b1;
                    end
                    emit       = 1'b1;
                    state_next = pph_pkg::S_IDLE;
                end
            end
            pph_pkg::S_RMW:
            begin
                if (slot_free)
                begin
                    // Write back the saturating increment
                    ram_we              = 1'b1;
                    ram_waddr           = bin_reg;
                    ram_wdata           = (cur_count == pph_pkg::COUNT_MAX)
                                        ? cur_count : cur_count + 1'b1;
                    valid_next[bin_reg] = 1'b1;
                    emit                = 1'b1;
                    state_next          = pph_pkg::S_IDLE;
                end
            end
            pph_pkg::S_RDATA:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_time  = time_reg;
                    emit_count = cur_count;
                    state_next = pph_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pph_pkg::S_IDLE;
            end
        endcase

        // Load the result beat from the updated run state
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_time_next  = emit_time;
            out_count_next = emit_count;
            out_done_next  = (seen_next >= done_limit);
            out_drop_next  = drop_next;
        end
    end

    // Lower limit write, falling back to the default when out of range
    assign cfg_lower = cfg_data[pph_pkg::LL_W-1:0];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pph_pkg::S_IDLE;
            valid_reg     <= '0;
            prev_reg      <= '0;
            seen_reg      <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
            lower_reg     <= pph_pkg::LOWER_DEFAULT;
            icount_reg    <= pph_pkg::COUNT_DEFAULT;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            prev_reg      <= prev_next;
            seen_reg      <= seen_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pph_pkg::CFG_LOWER_LIMIT:
                    begin
                        lower_reg <= (cfg_lower >= pph_pkg::LOWER_MIN &&
                                      cfg_lower <= pph_pkg::LOWER_MAX)
                                   ? cfg_lower : pph_pkg::LOWER_DEFAULT;
                    end
                    pph_pkg::CFG_INTERVAL_COUNT:
                    begin
                        icount_reg <= cfg_data[pph_pkg::IC_W-1:0];
                    end
                    default:
                    begin
                        icount_reg <= icount_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        period_reg    <= period_next;
        bin_reg       <= bin_next;
        time_reg      <= time_next;
        rd_valid_reg  <= rd_valid_next;
        out_time_reg  <= out_time_next;
        out_count_reg <= out_count_next;
        out_done_reg  <= out_done_next;
        out_drop_reg  <= out_drop_next;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam logic [pph_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [pph_pkg::TIME_W-1:0]  bin_time;
        logic [pph_pkg::COUNT_W-1:0] bin_count;
        logic                        done_res;
        logic [pph_pkg::COUNT_W-1:0] dropped;
    } bin_report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                            cfg_we;
    logic [pph_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pph_pkg::CFG_DATA_W-1:0]  cfg_data;

    pph_in_if  req_if ();
    pph_out_if rsp_if ();

    pulse_period_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the histogram state and registers
    logic [pph_pkg::COUNT_W-1:0]     bin_tally [pph_pkg::NUM_BINS];
    logic [pph_pkg::STAMP_WIDTH-1:0] last_stamp       = '0;
    logic [pph_pkg::SEEN_W-1:0]      captures_taken   = '0;
    logic [pph_pkg::COUNT_W-1:0]     drop_tally       = '0;
    logic [pph_pkg::LL_W-1:0]        lower_limit_q    = pph_pkg::LOWER_DEFAULT;
    logic [pph_pkg::IC_W-1:0]        interval_count_q = pph_pkg::COUNT_DEFAULT;

    bin_report_t awaited_reports [$];
    int mismatches  = 0;
    int send_idle   = 38;
    int recv_idle   = 71;
    int hold_left   = 0;
    int quiet_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic run_complete();
        return captures_taken >= ({1'b0, interval_count_q} + pph_pkg::WARMUP);
    endfunction

    // Advance the shadow state by one beat and return the report it yields
    function automatic bin_report_t step_histogram(input logic [pph_pkg::OP_W-1:0] op,
                                                   input logic [pph_pkg::TS_W-1:0] stamp,
                                                   input logic [pph_pkg::IDX_W-1:0] idx);
        bin_report_t                     rep;
        logic [pph_pkg::STAMP_WIDTH-1:0] now;
        logic [pph_pkg::STAMP_WIDTH-1:0] period;
        int unsigned                     slot;
        int unsigned                     label;
        rep = '0;
        now = stamp[pph_pkg::STAMP_WIDTH-1:0];
        case (op)
            pph_pkg::OP_START:
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
                last_stamp     = '0;
                captures_taken = '0;
                drop_tally     = '0;
            end
            pph_pkg::OP_CAPTURE:
            begin
                if (!run_complete())
                begin
                    if (captures_taken >= pph_pkg::WARMUP)
                    begin
                        period = now - last_stamp;
                        if (period >= lower_limit_q &&
                            period - lower_limit_q < pph_pkg::NUM_BINS)
                        begin
                            slot = period - lower_limit_q;
                            if (bin_tally[slot] != pph_pkg::COUNT_MAX)
                                bin_tally[slot] = bin_tally[slot] + 1'b1;
                        end
                        else if (drop_tally != pph_pkg::COUNT_MAX)
                        begin
                            drop_tally = drop_tally + 1'b1;
                        end
                    end
                    last_stamp     = now;
                    captures_taken = captures_taken + 1'b1;
                end
            end
            pph_pkg::OP_READ:
            begin
                if (idx < pph_pkg::NUM_BINS)
                begin
                    label         = lower_limit_q + idx;
                    rep.bin_time  = (label > pph_pkg::TIME_MAX) ? pph_pkg::TIME_MAX
                                                                : label[pph_pkg::TIME_W-1:0];
                    rep.bin_count = bin_tally[idx];
                end
            end
            default:
            begin
            end
        endcase
        rep.done_res = run_complete();
        rep.dropped  = drop_tally;
        return rep;
    endfunction

    // Offer one beat, wait for it to be taken, then queue its report
    task automatic send_beat(input logic [pph_pkg::OP_W-1:0] op,
                             input logic [pph_pkg::TS_W-1:0] stamp,
                             input int unsigned idx);
        logic [pph_pkg::IDX_W-1:0] idx_bits;
        idx_bits = idx[pph_pkg::IDX_W-1:0];
        while ($urandom_range(99) < send_idle)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.op        <= op;
        req_if.timestamp <= stamp;
        req_if.bin_index <= idx_bits;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        awaited_reports.push_back(step_histogram(op, stamp, idx_bits));
    endtask

    // Drop valid and let every outstanding report come back
    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [pph_pkg::CFG_INDEX_W-1:0] index,
                                  input int unsigned data);
        logic [pph_pkg::CFG_DATA_W-1:0] word;
        logic [pph_pkg::LL_W-1:0]       raw_lower;
        word      = data[pph_pkg::CFG_DATA_W-1:0];
        raw_lower = word[pph_pkg::LL_W-1:0];
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= word;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == pph_pkg::CFG_LOWER_LIMIT)
            lower_limit_q = (raw_lower >= pph_pkg::LOWER_MIN &&
                             raw_lower <= pph_pkg::LOWER_MAX) ?
                            raw_lower : pph_pkg::LOWER_DEFAULT;
        else if (index == pph_pkg::CFG_INTERVAL_COUNT)
            interval_count_q = word[pph_pkg::IC_W-1:0];
    endtask

    // Bins read as zero after reset; reads past the store and the unused op give zeros
    task automatic test_reset_state();
        send_beat(pph_pkg::OP_READ, $urandom, 0);
        send_beat(pph_pkg::OP_READ, '1, pph_pkg::NUM_BINS - 1);
        send_beat(pph_pkg::OP_READ, '0, 127);
        send_beat(OP_UNUSED, '1, 127);
        drain_results();
    endtask

    // Out-of-range lower limits fall back to the default; upper data bits are ignored
    task automatic test_lower_limit_range();
        int unsigned probes [4];
        probes = '{pph_pkg::LOWER_MIN - 1, pph_pkg::LOWER_MAX + 1,
                   16'hC000 | pph_pkg::LOWER_MIN, pph_pkg::LOWER_MAX};
        foreach (probes[i])
        begin
            write_register(pph_pkg::CFG_LOWER_LIMIT, probes[i]);
            send_beat(pph_pkg::OP_READ, $urandom,
                      (i == 3) ? pph_pkg::NUM_BINS - 1
                               : $urandom_range(pph_pkg::NUM_BINS - 1));
            drain_results();
        end
    endtask

    // Warm-up, wrap of the stamp, both bin edges, drops on each side, capture after done
    task automatic test_interval_window();
        logic [pph_pkg::TS_W-1:0] stamp;
        int                       shifts [6];
        shifts = '{0, pph_pkg::NUM_BINS - 1, -1, pph_pkg::NUM_BINS, 37, 0};
        write_register(pph_pkg::CFG_LOWER_LIMIT, pph_pkg::LOWER_MIN);
        write_register(pph_pkg::CFG_INTERVAL_COUNT, 5);
        send_beat(pph_pkg::OP_START, $urandom, $urandom_range(127));
        send_beat(pph_pkg::OP_CAPTURE, 32'h1234_5678, $urandom_range(127));
        stamp = 32'hFFFF_FFC0;
        send_beat(pph_pkg::OP_CAPTURE, stamp, $urandom_range(127));
        foreach (shifts[i])
        begin
            stamp += pph_pkg::LOWER_MIN + shifts[i];
            send_beat(pph_pkg::OP_CAPTURE, stamp, $urandom_range(127));
        end
        send_beat(pph_pkg::OP_READ, $urandom, 0);
        send_beat(pph_pkg::OP_READ, $urandom, pph_pkg::NUM_BINS - 1);
        send_beat(pph_pkg::OP_READ, $urandom, 37);
        send_beat(pph_pkg::OP_START, $urandom, $urandom_range(127));
        send_beat(pph_pkg::OP_READ, $urandom, 0);
        drain_results();
    endtask

    // With no intervals asked for, the run is done once the base is set
    task automatic test_zero_intervals();
        write_register(pph_pkg::CFG_INTERVAL_COUNT, 0);
        send_beat(pph_pkg::OP_START, $urandom, $urandom_range(127));
        repeat (3) send_beat(pph_pkg::OP_CAPTURE, $urandom, $urandom_range(127));
        send_beat(pph_pkg::OP_READ, $urandom, $urandom_range(pph_pkg::NUM_BINS - 1));
        drain_results();
    endtask

    // Runs with random settings: mostly periods inside the window, plus noise
    task automatic test_random_runs(input int send_pct, input int recv_pct, input int budget);
        logic [pph_pkg::TS_W-1:0] stamp;
        int unsigned              run_length;
        int                       sent;
        int                       steps;
        int                       capped;
        send_idle = send_pct;
        recv_idle = recv_pct;
        sent      = 0;
        while (sent < budget)
        begin
            case ($urandom_range(5))
                0: write_register(pph_pkg::CFG_LOWER_LIMIT, pph_pkg::LOWER_MIN);
                1: write_register(pph_pkg::CFG_LOWER_LIMIT, pph_pkg::LOWER_MAX);
                2: write_register(pph_pkg::CFG_LOWER_LIMIT, $urandom_range(16'hFFFF));
                default: write_register(pph_pkg::CFG_LOWER_LIMIT,
                                        $urandom_range(pph_pkg::LOWER_MAX,
                                                       pph_pkg::LOWER_MIN));
            endcase
            case ($urandom_range(7))
                0: run_length = 0;
                1: run_length = 16'hFFFF;
                default: run_length = $urandom_range(24, 1);
            endcase
            write_register(pph_pkg::CFG_INTERVAL_COUNT, run_length);
            capped = (run_length > 30) ? 30 : int'(run_length);
            steps  = capped + capped / 2 + 4 + $urandom_range(8);
            send_beat(pph_pkg::OP_START, $urandom, $urandom_range(127));
            stamp = $urandom;
            repeat (steps)
            begin
                case ($urandom_range(19))
                    0: send_beat(pph_pkg::OP_START, $urandom, $urandom_range(127));
                    1: send_beat(OP_UNUSED, $urandom, $urandom_range(127));
                    2, 3, 4:
                        send_beat(pph_pkg::OP_READ, $urandom,
                                  $urandom_range(pph_pkg::NUM_BINS - 1));
                    5: send_beat(pph_pkg::OP_READ, $urandom, $urandom_range(127));
                    6:
                    begin
                        stamp = $urandom;
                        send_beat(pph_pkg::OP_CAPTURE, stamp, $urandom_range(127));
                    end
                    7:
                    begin
                        case ($urandom_range(3))
                            0: stamp += lower_limit_q - 1;
                            1: stamp += lower_limit_q + pph_pkg::NUM_BINS;
                            2: stamp += lower_limit_q + pph_pkg::NUM_BINS - 1;
                            default: stamp += lower_limit_q;
                        endcase
                        send_beat(pph_pkg::OP_CAPTURE, stamp, $urandom_range(127));
                    end
                    default:
                    begin
                        stamp += lower_limit_q + $urandom_range(pph_pkg::NUM_BINS - 1);
                        send_beat(pph_pkg::OP_CAPTURE, stamp, $urandom_range(127));
                    end
                endcase
            end
            drain_results();
            sent += steps + 1;
        end
    endtask

    // Hold the result side off while the sender keeps pushing, so the input stalls
    task automatic test_output_hold_off();
        logic [pph_pkg::TS_W-1:0] stamp;
        send_idle = 0;
        write_register(pph_pkg::CFG_LOWER_LIMIT, 500);
        write_register(pph_pkg::CFG_INTERVAL_COUNT, 12);
        send_beat(pph_pkg::OP_START, $urandom, $urandom_range(127));
        hold_left = 300;
        stamp = $urandom;
        repeat (20)
        begin
            stamp += lower_limit_q + $urandom_range(pph_pkg::NUM_BINS - 1);
            send_beat(pph_pkg::OP_CAPTURE, stamp, $urandom_range(127));
        end
        repeat (4) send_beat(pph_pkg::OP_READ, $urandom,
                             $urandom_range(pph_pkg::NUM_BINS - 1));
        drain_results();
    endtask

    // Hit the top bin of the highest interval window with back-to-back captures
    task automatic test_top_window();
        logic [pph_pkg::TS_W-1:0] stamp;
        send_idle = 0;
        recv_idle = 0;
        write_register(pph_pkg::CFG_LOWER_LIMIT, pph_pkg::LOWER_MAX);
        write_register(pph_pkg::CFG_INTERVAL_COUNT, 16'hFFFF);
        send_beat(pph_pkg::OP_START, $urandom, $urandom_range(127));
        stamp = $urandom;
        repeat (10)
        begin
            stamp += pph_pkg::LOWER_MAX + pph_pkg::NUM_BINS - 1;
            send_beat(pph_pkg::OP_CAPTURE, stamp, $urandom_range(127));
        end
        send_beat(pph_pkg::OP_READ, $urandom, pph_pkg::NUM_BINS - 1);
        drain_results();
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Compare each result beat with the oldest queued report
    always @(posedge clk)
    begin : check_reports
        bin_report_t got;
        bin_report_t want;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got.bin_time  = rsp_if.bin_time;
            got.bin_count = rsp_if.bin_count;
            got.done_res  = rsp_if.done_res;
            got.dropped   = rsp_if.dropped;
            if (awaited_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing queued", $realtime);
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (got.bin_time !== want.bin_time || got.bin_count !== want.bin_count ||
                    got.done_res !== want.done_res || got.dropped !== want.dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected %0d %0d %0b %0d, got %0d %0d %0b %0d",
                                 $realtime, want.bin_time, want.bin_count,
                                 want.done_res, want.dropped, got.bin_time,
                                 got.bin_count, got.done_res, got.dropped);
                end
            end
        end
    end

    // Stop the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
        begin
            quiet_count <= 0;
        end
        else if (quiet_count >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial
    begin
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        req_if.valid     = 1'b0;
        req_if.op        = pph_pkg::OP_START;
        req_if.timestamp = '0;
        req_if.bin_index = '0;
        rsp_if.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = pph_pkg::CFG_LOWER_LIMIT;
        cfg_data         = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_lower_limit_range();
        test_interval_window();
        test_zero_intervals();
        test_random_runs(38, 71, 150);
        test_random_runs(71, 38, 150);
        test_output_hold_off();
        test_random_runs(0, 0, 150);
        test_top_window();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && awaited_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* pulse_period_histogram.f */
sv/pph_pkg.sv
sv/pph_in_if.sv
sv/pph_out_if.sv
sv/pph_ram.sv
sv/pulse_period_histogram.sv
tb/testbench.sv
